@@ hdl/tklt_pkg.sv @@
// Shared types and constants for the two-key lookup table.
`timescale 1ns / 1ps

package tklt_pkg;

    // Default table depth
    localparam int DEPTH_DEF = 64;

    // Opcodes
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_DEL_ID  = 3'd1;
    localparam logic [2:0] OP_LK_ID   = 3'd2;
    localparam logic [2:0] OP_LK_FILE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // One stored table entry
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] file;
        logic [31:0] handle;
    } entry_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;       // capture a new request, restart the scan
        logic       scan;       // issue the next table read
        logic       finish;     // register the result
        logic [1:0] status;     // result status on finish
        logic       found;      // return the handle of the hit entry
        logic       wr_en;      // write the table
        logic       wr_append;  // write at the fill count and grow it
        logic       cnt_clr;    // empty the table
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] op;         // opcode of the request under way
        logic       hit;        // entry under compare matches
        logic       exhausted;  // every used entry compared without a hit
        logic       full;       // fill count at the table depth
    } stat_t;

endpackage

@@ hdl/two_key_lookup_table.sv @@
// Top level of the two-key lookup table: controller, datapath and table RAM.
//
//  Channel   Handshake        Payload
//  request   start / busy     opcode, object_id, file_number, name_handle
//  result    done (strobe)    status, found_handle
//
// A request is taken on a clock edge with start high and busy low.
// Add, delete and both lookups scan the used entries through the single
// read port of the table RAM, one entry a cycle; clear and undefined
// opcodes finish without a scan.
// The result shows on done for one cycle, in which busy is already low.
// Reset empties the table (fill count zero); no clearing pass is needed.
// The result side cannot stall; it must take done as it comes.
`timescale 1ns / 1ps

module two_key_lookup_table
    import tklt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] object_id,
    input  logic [31:0] file_number,
    input  logic [31:0] name_handle,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] found_handle
);

    cmd_t  cmd;
    stat_t stat;

    tklt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    tklt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .object_id    (object_id),
        .file_number  (file_number),
        .name_handle  (name_handle),
        .done         (done),
        .status       (status),
        .found_handle (found_handle)
    );

endmodule

@@ hdl/tklt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tklt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/tklt_ctrl.sv @@
// Controller state machine: sequences one request through the table scan.
`timescale 1ns / 1ps

module tklt_ctrl
    import tklt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd    = '0;
        busy   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_EXEC:
            begin
                busy     = 1'b1;
                cmd.scan = 1'b1;
                case (stat.op)
                    OP_ADD:
                    begin
                        // reuse a free slot, else append unless full
                        if (stat.hit)
                        begin
                            cmd.finish = 1'b1;
                            cmd.wr_en  = 1'b1;
                        end
                        else if (stat.exhausted)
                        begin
                            cmd.finish = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_en     = 1'b1;
                                cmd.wr_append = 1'b1;
                            end
                        end
                    end
                    OP_DEL_ID:
                    begin
                        if (stat.hit)
                        begin
                            cmd.finish = 1'b1;
                            cmd.wr_en  = 1'b1;
                        end
                        else if (stat.exhausted)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_MISS;
                        end
                    end
                    OP_LK_ID, OP_LK_FILE:
                    begin
                        if (stat.hit)
                        begin
                            cmd.finish = 1'b1;
                            cmd.found  = 1'b1;
                        end
                        else if (stat.exhausted)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_MISS;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.finish  = 1'b1;
                        cmd.cnt_clr = 1'b1;
                    end
                    default:
                    begin
                        // undefined opcode: no effect, plain done
                        cmd.finish = 1'b1;
                    end
                endcase
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A request is only taken while idle, and a finish always returns to idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("request taken while busy");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE) && !busy)
        else $error("controller did not return to idle after finish");
    a_no_write_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (stat.op == OP_ADD || stat.op == OP_DEL_ID))
        else $error("table write on a request that must not write");

endmodule

@@ hdl/tklt_dp.sv @@
// Datapath: request registers, fill count, scan counter, compare and result registers.
`timescale 1ns / 1ps

module tklt_dp
    import tklt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [2:0]  opcode,
    input  logic [31:0] object_id,
    input  logic [31:0] file_number,
    input  logic [31:0] name_handle,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] found_handle
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Request registers
    logic [2:0]        op_reg;
    logic [31:0]       id_reg;
    logic [31:0]       file_reg;
    logic [31:0]       handle_reg;

    // Scan control
    logic [CNT_W-1:0]  used_count_reg, used_count_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [ADDR_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic              data_vld_reg, data_vld_next;

    // Result registers
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [31:0]       found_handle_reg;

    // Table port signals
    logic              rd_en;
    entry_t            rd_entry;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_entry;
    logic              match;

    tklt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= opcode;
            id_reg     <= object_id;
            file_reg   <= file_number;
            handle_reg <= name_handle;
        end
    end

    // Read issue: one used entry a cycle, none once the request finishes
    assign rd_en = cmd.scan && !cmd.finish && (scan_idx_reg < used_count_reg);

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        data_vld_next = 1'b0;
        if (cmd.load)
        begin
            scan_idx_next = '0;
        end
        else if (rd_en)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
            cmp_idx_next  = scan_idx_reg[ADDR_W-1:0];
            data_vld_next = 1'b1;
        end
    end

    // Entry compare, per opcode
    always_comb
    begin
        case (op_reg)
            OP_ADD:     match = (rd_entry.id == '0);
            OP_DEL_ID:  match = (rd_entry.id == id_reg);
            OP_LK_ID:   match = (rd_entry.id != '0) && (rd_entry.id == id_reg);
            OP_LK_FILE: match = (rd_entry.file != '0) && (rd_entry.file == file_reg);
            default:    match = 1'b0;
        endcase
    end

    assign stat.op        = op_reg;
    assign stat.hit       = data_vld_reg && match;
    assign stat.exhausted = !data_vld_reg && (scan_idx_reg >= used_count_reg);
    assign stat.full      = (used_count_reg == CNT_W'(DEPTH));

    // Table write: new entry on add, id and file cleared on delete
    assign wr_en   = cmd.wr_en;
    assign wr_addr = cmd.wr_append ? used_count_reg[ADDR_W-1:0] : cmp_idx_reg;

    always_comb
    begin
        if (op_reg == OP_ADD)
        begin
            wr_entry.id     = id_reg;
            wr_entry.file   = file_reg;
            wr_entry.handle = handle_reg;
        end
        else
        begin
            wr_entry.id     = '0;
            wr_entry.file   = '0;
            wr_entry.handle = rd_entry.handle;
        end
    end

    // Fill count
    always_comb
    begin
        used_count_next = used_count_reg;
        if (cmd.cnt_clr)
        begin
            used_count_next = '0;
        end
        else if (cmd.wr_en && cmd.wr_append)
        begin
            used_count_next = used_count_reg + CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
            scan_idx_reg   <= '0;
            data_vld_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            used_count_reg <= used_count_next;
            scan_idx_reg   <= scan_idx_next;
            data_vld_reg   <= data_vld_next;
            done_reg       <= cmd.finish;
        end
    end

    // Compare index and result payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        if (cmd.finish)
        begin
            status_reg       <= cmd.status;
            found_handle_reg <= cmd.found ? rd_entry.handle : '0;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign found_handle = found_handle_reg;

    // Fill count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond table depth");
    // Only entries below the fill count are ever compared
    a_cmp_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        data_vld_reg |-> (CNT_W'(cmp_idx_reg) < used_count_reg))
        else $error("compare of an entry outside the used range");
    // Append never happens on a full table
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_append) |-> !stat.full)
        else $error("append on a full table");
    // Results never come back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

endmodule

@@ bench/tklt_result_checker.sv @@
// Result checker for the two-key lookup table: shadow table, prediction and compare.
`timescale 1ns / 1ps

module tklt_result_checker
    import tklt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] object_id,
    input  logic [31:0] file_number,
    input  logic [31:0] name_handle,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [31:0] found_handle,
    output int          mismatch_count,
    output int          awaited_count
);

    // keep the log readable when the block is badly broken
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle;
    } reply_t;

    // Shadow of the table contents and its fill count
    logic [31:0] shadow_ids     [DEPTH];
    logic [31:0] shadow_files   [DEPTH];
    logic [31:0] shadow_handles [DEPTH];
    int          shadow_fill;
    int          fail_tally;

    // Replies owed by the block, oldest first
    reply_t      awaited_replies[$];

    initial
    begin
        shadow_fill    = 0;
        fail_tally     = 0;
        mismatch_count = 0;
        awaited_count  = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_tally < PRINT_LIMIT)
            $display("[%0t] result mismatch: %s", $time, what);
        fail_tally++;
    endtask

    // Apply one request to the shadow table and work out the reply it earns
    function automatic reply_t run_request(input logic [2:0]  op,
                                           input logic [31:0] id,
                                           input logic [31:0] file,
                                           input logic [31:0] handle);
        reply_t r;
        int     slot;
        bit     hit;
        r.status = ST_DONE;
        r.handle = '0;
        hit      = 1'b0;
        slot     = shadow_fill;
        case (op)
            OP_ADD:
            begin
                // first freed slot wins, else append
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (!hit && shadow_ids[i] == '0)
                    begin
                        slot = i;
                        hit  = 1'b1;
                    end
                end
                if (!hit && shadow_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (!hit)
                        shadow_fill++;
                    shadow_ids[slot]     = id;
                    shadow_files[slot]   = file;
                    shadow_handles[slot] = handle;
                end
            end
            OP_DEL_ID:
            begin
                // an id of 0 matches a freed slot too
                r.status = ST_MISS;
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (!hit && shadow_ids[i] == id)
                    begin
                        shadow_ids[i]   = '0;
                        shadow_files[i] = '0;
                        r.status        = ST_DONE;
                        hit             = 1'b1;
                    end
                end
            end
            OP_LK_ID:
            begin
                r.status = ST_MISS;
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (!hit && shadow_ids[i] != '0 && shadow_ids[i] == id)
                    begin
                        r.handle = shadow_handles[i];
                        r.status = ST_DONE;
                        hit      = 1'b1;
                    end
                end
            end
            OP_LK_FILE:
            begin
                r.status = ST_MISS;
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (!hit && shadow_files[i] != '0 && shadow_files[i] == file)
                    begin
                        r.handle = shadow_handles[i];
                        r.status = ST_DONE;
                        hit      = 1'b1;
                    end
                end
            end
            OP_CLEAR:
                shadow_fill = 0;
            default:
                ; // undefined opcode: no effect, plain done
        endcase
        return r;
    endfunction

    // Compare each result with the oldest reply owed, then log any new request
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            shadow_fill = 0;
            awaited_replies.delete();
        end
        else
        begin
            if (done)
            begin
                if (awaited_replies.size() == 0)
                    report_mismatch($sformatf("unexpected result status=%0d handle=%h",
                                              status, found_handle));
                else
                begin
                    want = awaited_replies.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (found_handle !== want.handle)
                        report_mismatch($sformatf("found_handle %h, expected %h",
                                                  found_handle, want.handle));
                end
            end
            if (start && !busy)
                awaited_replies.push_back(run_request(opcode, object_id,
                                                      file_number, name_handle));
        end
        awaited_count  <= awaited_replies.size();
        mismatch_count <= fail_tally;
    end

endmodule

@@ bench/two_key_lookup_table_tb.sv @@
// Testbench top for the two-key lookup table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module two_key_lookup_table_tb;
    import tklt_pkg::*;

    localparam int         DEPTH         = DEPTH_DEF;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         RANDOM_ITEMS  = 950;
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  opcode;
    logic [31:0] object_id;
    logic [31:0] file_number;
    logic [31:0] name_handle;
    logic        done;
    logic [1:0]  status;
    logic [31:0] found_handle;

    int mismatch_count;
    int awaited_count;
    int idle_cycles;
    int defined_sent;   // requests with a defined opcode
    int calm_left;      // requests still to go back to back
    int key_span;       // keys mostly drawn from 1..key_span so that they collide

    two_key_lookup_table #(
        .DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .object_id    (object_id),
        .file_number  (file_number),
        .name_handle  (name_handle),
        .done         (done),
        .status       (status),
        .found_handle (found_handle)
    );

    tklt_result_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .object_id      (object_id),
        .file_number    (file_number),
        .name_handle    (name_handle),
        .done           (done),
        .status         (status),
        .found_handle   (found_handle),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: too long without a request taken or a result given
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Gap after a request: mostly none or short, a few long, some calm runs
    function automatic int pick_gap();
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 45)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Key: mostly from a small pool, sometimes zero, near all-ones or fully random
    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 80)
            return 32'($urandom_range(1, key_span));
        if (roll < 88)
            return ~32'($urandom_range(0, 3));
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return OP_ADD;
        if (roll < 58)
            return OP_DEL_ID;
        if (roll < 76)
            return OP_LK_ID;
        if (roll < 94)
            return OP_LK_FILE;
        if (roll < 97)
            return OP_CLEAR;
        return 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    endfunction

    // Hold one request until the block takes it, then idle for a random gap, which may be empty
    task automatic send_request(input logic [2:0]  op,
                                input logic [31:0] id,
                                input logic [31:0] file,
                                input logic [31:0] handle);
        int gap;
        start       <= 1'b1;
        opcode      <= op;
        object_id   <= id;
        file_number <= file;
        name_handle <= handle;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op <= OP_CLEAR)
            defined_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            // junk on the payload while start is low
            start       <= 1'b0;
            opcode      <= 3'($urandom());
            object_id   <= $urandom();
            file_number <= $urandom();
            name_handle <= $urandom();
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int kind;
        int episode;
        start        = 1'b0;
        opcode       = OP_ADD;
        object_id    = '0;
        file_number  = '0;
        name_handle  = '0;
        rst_n        = 1'b0;
        idle_cycles  = 0;
        defined_sent = 0;
        calm_left    = 0;
        key_span     = 8;
        episode      = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, extremes, freed slots, duplicates, undefined opcodes
        send_request(OP_LK_ID,   32'd1, 32'd1, 32'd0);
        send_request(OP_LK_FILE, 32'd1, 32'd1, 32'd0);
        send_request(OP_DEL_ID,  32'd1, 32'd1, 32'd0);
        send_request(OP_ADD,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_ADD,     32'd0, 32'd5, 32'hA5A5_A5A5);   // id 0: slot stays free
        send_request(OP_LK_ID,   32'd0, 32'd0, 32'd0);           // id 0 never matches
        send_request(OP_LK_FILE, 32'd0, 32'd5, 32'd0);           // but its file number does
        send_request(OP_ADD,     32'd1, 32'd0, 32'd1);           // reuses the free slot
        send_request(OP_LK_FILE, 32'd0, 32'd0, 32'd0);           // file 0 never matches
        send_request(OP_LK_ID,   32'hFFFF_FFFF, 32'd0, 32'd0);
        send_request(OP_LK_FILE, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_ADD,     32'd1, 32'd7, 32'd2);           // duplicate id
        send_request(OP_LK_ID,   32'd1, 32'd0, 32'd0);           // first copy wins
        send_request(OP_DEL_ID,  32'd1, 32'd0, 32'd0);
        send_request(OP_LK_ID,   32'd1, 32'd0, 32'd0);           // now the second copy
        send_request(OP_LK_FILE, 32'd0, 32'd7, 32'd0);
        send_request(OP_DEL_ID,  32'd0, 32'd0, 32'd0);           // hits the freed slot
        send_request(OP_ADD,     32'd2, 32'd2, 32'd3);
        for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++)
            send_request(3'(op), $urandom(), $urandom(), $urandom());
        send_request(OP_CLEAR,   32'd0, 32'd0, 32'd0);
        send_request(OP_LK_ID,   32'd2, 32'd2, 32'd0);           // gone after clear
        send_request(OP_ADD,     32'h8000_0000, 32'd1, 32'd0);
        send_request(OP_LK_ID,   32'h8000_0000, 32'd0, 32'd0);   // found, handle 0

        // Random: episodes of mixed traffic, table fills past full, and noise
        defined_sent = 0;
        while (defined_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (episode == 2 || kind == 0)
            begin
                // fill past the depth, then probe and punch holes
                key_span = 3 * DEPTH;
                send_request(OP_CLEAR, pick_key(), pick_key(), $urandom());
                repeat (DEPTH + 3)
                    send_request(OP_ADD, 32'($urandom_range(1, key_span)),
                                 32'($urandom_range(1, key_span)), $urandom());
                repeat (24)
                    send_request(3'($urandom_range(OP_ADD, OP_LK_FILE)), pick_key(),
                                 pick_key(), $urandom());
            end
            else if (kind == 1)
            begin
                repeat (12)
                    send_request(3'($urandom()), $urandom(), $urandom(), $urandom());
            end
            else
            begin
                key_span = ($urandom_range(0, 1) != 0) ? 6 : 40;
                repeat (30)
                    send_request(pick_op(), pick_key(), pick_key(), $urandom());
            end
            episode++;
        end
        start <= 1'b0;

        // Drain: every reply in, then a full scan's worth of quiet
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
